// ===== rtl/core/ps2k_pkg.sv =====
// Shared types, codes and the key lookup table of the PS/2 terminal keyboard decoder.
package ps2k_pkg;

    localparam logic [7:0] CODE_BREAK    = 8'hF0;
    localparam logic [7:0] CODE_EXTENDED = 8'hE0;
    localparam logic [7:0] ROM_DEPTH     = 8'd126;

    localparam logic [7:0] CHAR_AT     = 8'h40;
    localparam logic [7:0] CHAR_UNDER  = 8'h5F;
    localparam logic [7:0] CHAR_LBRACE = 8'h7B;
    localparam logic [7:0] CHAR_BAR    = 8'h7C;
    localparam logic [7:0] CHAR_RBRACE = 8'h7D;
    localparam logic [7:0] CHAR_LBRACK = 8'h5B;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_RBRACK = 8'h5D;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_BS     = 8'h08;
    localparam logic [7:0] CHAR_ESC    = 8'h1B;
    localparam logic [7:0] CHAR_DEL    = 8'h7F;

    localparam logic [7:0] CMD_RESET       = 8'd0;
    localparam logic [7:0] CMD_TAB_FLIP    = 8'd1;
    localparam logic [7:0] CMD_CLEAR_TABS  = 8'd2;
    localparam logic [7:0] CMD_LOCAL       = 8'd3;
    localparam logic [7:0] CMD_SWITCH      = 8'd4;
    localparam logic [7:0] CMD_VALUE_FLIP  = 8'd5;
    localparam logic [7:0] CMD_UART_TX     = 8'd6;
    localparam logic [7:0] CMD_UART_RX     = 8'd7;
    localparam logic [7:0] CMD_COLUMN_MODE = 8'd8;
    localparam logic [7:0] CMD_NEXT        = 8'd9;
    localparam logic [7:0] CMD_SAVE        = 8'd10;
    localparam logic [7:0] CMD_RECALL      = 8'd11;
    localparam logic [7:0] CMD_PREVIOUS    = 8'd12;
    localparam logic [7:0] CMD_DIMMER      = 8'd13;
    localparam logic [7:0] CMD_BRIGHTER    = 8'd14;

    typedef enum logic [3:0] {
        CLS_NONE     = 4'd0,
        CLS_ALPHA    = 4'd1,
        CLS_SPEC     = 4'd2,
        CLS_PF       = 4'd3,
        CLS_SETUPKEY = 4'd4,
        CLS_TAB      = 4'd5,
        CLS_SHIFT    = 4'd6,
        CLS_CTRL     = 4'd7,
        CLS_CAPS     = 4'd8,
        CLS_ENTER    = 4'd9,
        CLS_BKSP     = 4'd10,
        CLS_ESC      = 4'd11,
        CLS_KPDIG    = 4'd12,
        CLS_KPNAV    = 4'd13,
        CLS_KPDOT    = 4'd14,
        CLS_KPDASH   = 4'd15
    } key_cls_t;

    typedef enum logic [3:0] {
        KIND_CLICK     = 4'd0,
        KIND_ASCII     = 4'd1,
        KIND_KP_DIGIT  = 4'd2,
        KIND_KP_DOT    = 4'd3,
        KIND_KP_DASH   = 4'd4,
        KIND_KP_ENTER  = 4'd5,
        KIND_RETURN    = 4'd6,
        KIND_ARROW     = 4'd7,
        KIND_PF        = 4'd8,
        KIND_SETUP     = 4'd9,
        KIND_SETUP_CMD = 4'd10
    } event_kind_t;

    typedef struct packed {
        key_cls_t   cls;
        logic [7:0] lo;
        logic [7:0] hi;
    } key_entry_t;

    typedef struct packed {
        logic        has;
        event_kind_t kind;
        logic [7:0]  value;
        logic        click;
    } result_t;

    function automatic key_entry_t key_lookup(input logic [6:0] idx);
        key_entry_t e;
        e = '{CLS_NONE, 8'h00, 8'h00};
        case (idx)
            7'd3:    e = '{CLS_SETUPKEY, 8'h00, 8'h00};
            7'd4:    e = '{CLS_PF, 8'd3, 8'h00};
            7'd5:    e = '{CLS_PF, 8'd1, 8'h00};
            7'd6:    e = '{CLS_PF, 8'd2, 8'h00};
            7'd12:   e = '{CLS_PF, 8'd4, 8'h00};
            7'd13:   e = '{CLS_TAB, 8'h00, 8'h00};
            7'd14:   e = '{CLS_SPEC, 8'h60, 8'h7E};
            7'd18:   e = '{CLS_SHIFT, 8'h00, 8'h00};
            7'd20:   e = '{CLS_CTRL, 8'h00, 8'h00};
            7'd21:   e = '{CLS_ALPHA, 8'h71, 8'h51};
            7'd22:   e = '{CLS_SPEC, 8'h31, 8'h21};
            7'd26:   e = '{CLS_ALPHA, 8'h7A, 8'h5A};
            7'd27:   e = '{CLS_ALPHA, 8'h73, 8'h53};
            7'd28:   e = '{CLS_ALPHA, 8'h61, 8'h41};
            7'd29:   e = '{CLS_ALPHA, 8'h77, 8'h57};
            7'd30:   e = '{CLS_SPEC, 8'h32, 8'h40};
            7'd33:   e = '{CLS_ALPHA, 8'h63, 8'h43};
            7'd34:   e = '{CLS_ALPHA, 8'h78, 8'h58};
            7'd35:   e = '{CLS_ALPHA, 8'h64, 8'h44};
            7'd36:   e = '{CLS_ALPHA, 8'h65, 8'h45};
            7'd37:   e = '{CLS_SPEC, 8'h34, 8'h24};
            7'd38:   e = '{CLS_SPEC, 8'h33, 8'h23};
            7'd41:   e = '{CLS_ALPHA, 8'h20, 8'h20};
            7'd42:   e = '{CLS_ALPHA, 8'h76, 8'h56};
            7'd43:   e = '{CLS_ALPHA, 8'h66, 8'h46};
            7'd44:   e = '{CLS_ALPHA, 8'h74, 8'h54};
            7'd45:   e = '{CLS_ALPHA, 8'h72, 8'h52};
            7'd46:   e = '{CLS_SPEC, 8'h35, 8'h25};
            7'd49:   e = '{CLS_ALPHA, 8'h6E, 8'h4E};
            7'd50:   e = '{CLS_ALPHA, 8'h62, 8'h42};
            7'd51:   e = '{CLS_ALPHA, 8'h68, 8'h48};
            7'd52:   e = '{CLS_ALPHA, 8'h67, 8'h47};
            7'd53:   e = '{CLS_ALPHA, 8'h79, 8'h59};
            7'd54:   e = '{CLS_SPEC, 8'h36, 8'h5E};
            7'd58:   e = '{CLS_ALPHA, 8'h6D, 8'h4D};
            7'd59:   e = '{CLS_ALPHA, 8'h6A, 8'h4A};
            7'd60:   e = '{CLS_ALPHA, 8'h75, 8'h55};
            7'd61:   e = '{CLS_SPEC, 8'h37, 8'h26};
            7'd62:   e = '{CLS_SPEC, 8'h38, 8'h2A};
            7'd65:   e = '{CLS_SPEC, 8'h2C, 8'h3C};
            7'd66:   e = '{CLS_ALPHA, 8'h6B, 8'h4B};
            7'd67:   e = '{CLS_ALPHA, 8'h69, 8'h49};
            7'd68:   e = '{CLS_ALPHA, 8'h6F, 8'h4F};
            7'd69:   e = '{CLS_SPEC, 8'h30, 8'h29};
            7'd70:   e = '{CLS_SPEC, 8'h39, 8'h28};
            7'd73:   e = '{CLS_SPEC, 8'h2E, 8'h3E};
            7'd74:   e = '{CLS_SPEC, 8'h2F, 8'h3F};
            7'd75:   e = '{CLS_ALPHA, 8'h6C, 8'h4C};
            7'd76:   e = '{CLS_SPEC, 8'h3B, 8'h3A};
            7'd77:   e = '{CLS_ALPHA, 8'h70, 8'h50};
            7'd78:   e = '{CLS_SPEC, 8'h2D, 8'h5F};
            7'd82:   e = '{CLS_SPEC, 8'h27, 8'h22};
            7'd84:   e = '{CLS_SPEC, 8'h5B, 8'h7B};
            7'd85:   e = '{CLS_SPEC, 8'h3D, 8'h2B};
            7'd88:   e = '{CLS_CAPS, 8'h00, 8'h00};
            7'd89:   e = '{CLS_SHIFT, 8'h00, 8'h00};
            7'd90:   e = '{CLS_ENTER, 8'h00, 8'h00};
            7'd91:   e = '{CLS_SPEC, 8'h5D, 8'h7D};
            7'd93:   e = '{CLS_SPEC, 8'h5C, 8'h7C};
            7'd102:  e = '{CLS_BKSP, 8'h00, 8'h00};
            7'd105:  e = '{CLS_KPDIG, 8'd1, 8'd1};
            7'd107:  e = '{CLS_KPNAV, 8'd4, 8'd2};
            7'd108:  e = '{CLS_KPDIG, 8'd7, 8'd1};
            7'd112:  e = '{CLS_KPDIG, 8'd0, 8'd1};
            7'd113:  e = '{CLS_KPDOT, 8'h00, 8'h00};
            7'd114:  e = '{CLS_KPNAV, 8'd2, 8'd1};
            7'd115:  e = '{CLS_KPDIG, 8'd5, 8'd1};
            7'd116:  e = '{CLS_KPNAV, 8'd6, 8'd3};
            7'd117:  e = '{CLS_KPNAV, 8'd8, 8'd0};
            7'd118:  e = '{CLS_ESC, 8'h00, 8'h00};
            7'd121:  e = '{CLS_SPEC, 8'h2B, 8'h2B};
            7'd122:  e = '{CLS_KPDIG, 8'd3, 8'd0};
            7'd123:  e = '{CLS_KPDASH, 8'h00, 8'h00};
            7'd124:  e = '{CLS_SPEC, 8'h2A, 8'h2A};
            7'd125:  e = '{CLS_KPDIG, 8'd9, 8'd1};
            default: e = '{CLS_NONE, 8'h00, 8'h00};
        endcase
        return e;
    endfunction

endpackage

// ===== rtl/core/ps2k_decode.sv =====
// Keyboard state flags and the combinational decode of one registered scan byte.
module ps2k_decode
    import ps2k_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic [7:0] scan_code,
    input  logic       setup_mode,
    input  logic       keyclick_enable,
    output result_t    result
);

    logic break_reg, break_next;
    logic extended_reg, extended_next;
    logic shift_reg, shift_next;
    logic ctrl_reg, ctrl_next;
    logic caps_reg, caps_next;

    key_entry_t entry;

    assign entry = key_lookup(scan_code[6:0]);

    always_comb
    begin
        logic        emitted;
        event_kind_t kind;
        logic [7:0]  value;
        logic        clicks;
        logic [7:0]  ch;
        logic        alt;
        logic        c;

        break_next    = break_reg;
        extended_next = extended_reg;
        shift_next    = shift_reg;
        ctrl_next     = ctrl_reg;
        caps_next     = caps_reg;
        emitted       = 1'b0;
        kind          = KIND_CLICK;
        value         = 8'h00;
        clicks        = 1'b1;
        ch            = entry.hi;
        alt           = 1'b0;

        if (scan_code >= ROM_DEPTH)
        begin
            if (scan_code == CODE_BREAK)
            begin
                break_next = 1'b1;
            end
            else if (scan_code == CODE_EXTENDED)
            begin
                extended_next = 1'b1;
            end
        end
        else
        begin
            break_next    = 1'b0;
            extended_next = 1'b0;
            case (entry.cls)
                CLS_SHIFT: shift_next = !break_reg;
                CLS_CTRL:  ctrl_next  = !break_reg;
                CLS_CAPS:
                begin
                    if (!break_reg)
                    begin
                        caps_next = !caps_reg;
                        emitted   = 1'b1;
                    end
                end
                CLS_ALPHA, CLS_SPEC:
                begin
                    if (!break_reg)
                    begin
                        if (setup_mode)
                        begin
                            kind    = KIND_SETUP_CMD;
                            emitted = 1'b1;
                            case (entry.lo)
                                8'h30:      value = CMD_RESET;
                                8'h32:      value = CMD_TAB_FLIP;
                                8'h33:      value = CMD_CLEAR_TABS;
                                8'h34:      value = CMD_LOCAL;
                                8'h35:      value = CMD_SWITCH;
                                8'h36:      value = CMD_VALUE_FLIP;
                                8'h37:      value = CMD_UART_TX;
                                8'h38:      value = CMD_UART_RX;
                                8'h39:      value = CMD_COLUMN_MODE;
                                CHAR_SPACE: value = CMD_NEXT;
                                8'h73:
                                begin
                                    value   = CMD_SAVE;
                                    emitted = shift_reg;
                                end
                                8'h72:
                                begin
                                    value   = CMD_RECALL;
                                    emitted = shift_reg;
                                end
                                default:    emitted = 1'b0;
                            endcase
                        end
                        else if (ctrl_reg)
                        begin
                            if (entry.hi == CHAR_LBRACE)
                            begin
                                ch = CHAR_LBRACK;
                            end
                            else if (entry.hi == CHAR_BAR)
                            begin
                                ch = CHAR_BSLASH;
                            end
                            else if (entry.hi == CHAR_RBRACE)
                            begin
                                ch = CHAR_RBRACK;
                            end
                            kind    = KIND_ASCII;
                            value   = ch - CHAR_AT;
                            emitted = (ch >= CHAR_AT) && (ch <= CHAR_UNDER);
                        end
                        else
                        begin
                            alt     = ((entry.cls == CLS_ALPHA) && caps_reg) != shift_reg;
                            kind    = KIND_ASCII;
                            value   = alt ? entry.hi : entry.lo;
                            emitted = 1'b1;
                        end
                    end
                end
                CLS_PF:
                begin
                    emitted = !break_reg;
                    kind    = KIND_PF;
                    value   = entry.lo;
                end
                CLS_SETUPKEY:
                begin
                    emitted = !break_reg;
                    kind    = KIND_SETUP;
                end
                CLS_TAB:
                begin
                    emitted = !break_reg;
                    kind    = setup_mode ? KIND_SETUP_CMD : KIND_ASCII;
                    value   = setup_mode ? CMD_NEXT : CHAR_TAB;
                end
                CLS_BKSP:
                begin
                    emitted = !break_reg;
                    kind    = setup_mode ? KIND_SETUP_CMD : KIND_ASCII;
                    value   = setup_mode ? CMD_PREVIOUS : CHAR_BS;
                end
                CLS_ESC:
                begin
                    emitted = !break_reg && !setup_mode;
                    kind    = KIND_ASCII;
                    value   = CHAR_ESC;
                end
                CLS_ENTER:
                begin
                    if (setup_mode)
                    begin
                        emitted = !break_reg && !extended_reg;
                        kind    = KIND_SETUP_CMD;
                        value   = CMD_NEXT;
                    end
                    else
                    begin
                        emitted = !break_reg;
                        kind    = extended_reg ? KIND_KP_ENTER : KIND_RETURN;
                    end
                end
                CLS_KPDIG:
                begin
                    emitted = !break_reg;
                    kind    = KIND_KP_DIGIT;
                    value   = entry.lo;
                    clicks  = (entry.hi != 8'h00);
                end
                CLS_KPDOT:
                begin
                    emitted = !break_reg;
                    kind    = extended_reg ? KIND_ASCII : KIND_KP_DOT;
                    value   = extended_reg ? CHAR_DEL : 8'h00;
                end
                CLS_KPDASH:
                begin
                    emitted = !break_reg && !setup_mode;
                    kind    = KIND_KP_DASH;
                end
                CLS_KPNAV:
                begin
                    emitted = !break_reg;
                    if (setup_mode)
                    begin
                        kind = KIND_SETUP_CMD;
                        case (entry.lo)
                            8'd2:    value = CMD_DIMMER;
                            8'd4:    value = CMD_PREVIOUS;
                            8'd6:    value = CMD_NEXT;
                            default: value = CMD_BRIGHTER;
                        endcase
                    end
                    else if (extended_reg)
                    begin
                        kind  = KIND_ARROW;
                        value = entry.hi;
                    end
                    else
                    begin
                        kind  = KIND_KP_DIGIT;
                        value = entry.lo;
                    end
                end
                default: emitted = 1'b0;
            endcase
        end

        c            = clicks && keyclick_enable;
        result.has   = emitted && !((kind == KIND_CLICK) && !c);
        result.kind  = kind;
        result.value = value;
        result.click = c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            break_reg    <= 1'b0;
            extended_reg <= 1'b0;
            shift_reg    <= 1'b0;
            ctrl_reg     <= 1'b0;
            caps_reg     <= 1'b0;
        end
        else if (advance)
        begin
            break_reg    <= break_next;
            extended_reg <= extended_next;
            shift_reg    <= shift_next;
            ctrl_reg     <= ctrl_next;
            caps_reg     <= caps_next;
        end
    end

endmodule

// ===== rtl/core/ps2k_out_reg.sv =====
// Result register that holds one decoded item until the output side takes it.
module ps2k_out_reg
    import ps2k_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  result_t     din,
    input  logic        out_stall,
    output logic        out_free,
    output logic        out_valid,
    output logic [3:0]  event_kind,
    output logic [7:0]  event_value,
    output logic        click
);

    logic        valid_reg;
    event_kind_t kind_reg;
    logic [7:0]  value_reg;
    logic        click_reg;

    assign out_free    = !valid_reg || !out_stall;
    assign out_valid   = valid_reg;
    assign event_kind  = kind_reg;
    assign event_value = value_reg;
    assign click       = click_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= din.has;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= din.kind;
            value_reg <= din.value;
            click_reg <= din.click;
        end
    end

endmodule

// ===== rtl/core/ps2_scan_code_to_terminal_keys_core.sv =====
// Top level of the PS/2 set-2 scan byte to terminal key event decoder.
// An accepted item is held in the input register and decoded; its result, if any,
// is loaded into the result register. Throughput: one item per cycle while the
// output side does not stall, set by the single decode stage between registers.
// Reset clears all key flags and pending prefixes and sets the key click enable.
module ps2_scan_code_to_terminal_keys_core
    import ps2k_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       keyclick_we,
    input  logic       keyclick_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] scan_code,
    input  logic       setup_mode,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] event_kind,
    output logic [7:0] event_value,
    output logic       click
);

    logic       keyclick_enable_reg;
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_code_reg;
    logic       s1_setup_reg;
    logic       accept;
    logic       advance;
    logic       out_free;
    result_t    result;

    assign advance  = s1_valid_reg && (!result.has || out_free);
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg        <= 1'b0;
            keyclick_enable_reg <= 1'b1;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (keyclick_we)
            begin
                keyclick_enable_reg <= keyclick_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_code_reg  <= scan_code;
            s1_setup_reg <= setup_mode;
        end
    end

    ps2k_decode u_decode (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .scan_code       (s1_code_reg),
        .setup_mode      (s1_setup_reg),
        .keyclick_enable (keyclick_enable_reg),
        .result          (result)
    );

    ps2k_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance && result.has),
        .din         (result),
        .out_stall   (out_stall),
        .out_free    (out_free),
        .out_valid   (out_valid),
        .event_kind  (event_kind),
        .event_value (event_value),
        .click       (click)
    );

    // An input item can only be held back by a full stage in front of it.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with an empty decode stage");

    // A stage holding a result is never lost while the output side stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall && s1_valid_reg && result.has) |-> in_stall)
        else $error("decode stage advanced into an occupied result register");

    // A click-only item exists only to sound the click.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (event_kind == KIND_CLICK)) |-> click)
        else $error("click-only item without click");

    // Clicks sound only while they are enabled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && click) |-> keyclick_enable_reg)
        else $error("click while key click is disabled");

endmodule

// ===== verif/ps2_scan_code_to_terminal_keys_core_tb.sv =====
// Self-checking testbench for the PS/2 scan byte to terminal key event decoder.
module ps2_scan_code_to_terminal_keys_core_tb;
    import ps2k_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_PRINTED    = 50;

    localparam logic [7:0] SC_LOWEST  = 8'h00;
    localparam logic [7:0] SC_TOP     = 8'hFF;
    localparam logic [7:0] SC_SETUP   = 8'h03;
    localparam logic [7:0] SC_PF1     = 8'h05;
    localparam logic [7:0] SC_LSHIFT  = 8'h12;
    localparam logic [7:0] SC_CTRL    = 8'h14;
    localparam logic [7:0] SC_1       = 8'h16;
    localparam logic [7:0] SC_S       = 8'h1B;
    localparam logic [7:0] SC_A       = 8'h1C;
    localparam logic [7:0] SC_R       = 8'h2D;
    localparam logic [7:0] SC_ZERO    = 8'h45;
    localparam logic [7:0] SC_LBRACK  = 8'h54;
    localparam logic [7:0] SC_CAPS    = 8'h58;
    localparam logic [7:0] SC_RSHIFT  = 8'h59;
    localparam logic [7:0] SC_ENTER   = 8'h5A;
    localparam logic [7:0] SC_KP4     = 8'h6B;
    localparam logic [7:0] SC_KP_DOT  = 8'h71;
    localparam logic [7:0] SC_KP8     = 8'h75;
    localparam logic [7:0] SC_ESC     = 8'h76;
    localparam logic [7:0] SC_KP3     = 8'h7A;
    localparam logic [7:0] SC_KP_DASH = 8'h7B;
    localparam logic [7:0] SC_KP9     = 8'h7D;

    typedef struct packed {
        key_cls_t   cls;
        logic [7:0] lo;
        logic [7:0] hi;
    } key_row_t;

    typedef struct packed {
        logic        has;
        event_kind_t kind;
        logic [7:0]  value;
        logic        click;
    } key_event_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       keyclick_we = 1'b0;
    logic       keyclick_wdata = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] scan_code = 8'h00;
    logic       setup_mode = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [3:0] event_kind;
    logic [7:0] event_value;
    logic       click;

    logic kc_en = 1'b1;
    logic brk_pend = 1'b0;
    logic ext_pend = 1'b0;
    logic shift_on = 1'b0;
    logic ctrl_on = 1'b0;
    logic caps_on = 1'b0;

    logic       steady = 1'b0;
    int         errors = 0;
    int         items_sent = 0;
    int         idle_cycles = 0;
    key_event_t pending_events[$];
    logic [7:0] key_codes[$];

    ps2_scan_code_to_terminal_keys_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .keyclick_we    (keyclick_we),
        .keyclick_wdata (keyclick_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .scan_code      (scan_code),
        .setup_mode     (setup_mode),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_kind     (event_kind),
        .event_value    (event_value),
        .click          (click)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic key_row_t key_row(input logic [6:0] code);
        key_row_t row;
        row = '{CLS_NONE, 8'h00, 8'h00};
        case (code)
            7'd3:   row = '{CLS_SETUPKEY, 8'h00, 8'h00};
            7'd4:   row = '{CLS_PF, 8'd3, 8'h00};
            7'd5:   row = '{CLS_PF, 8'd1, 8'h00};
            7'd6:   row = '{CLS_PF, 8'd2, 8'h00};
            7'd12:  row = '{CLS_PF, 8'd4, 8'h00};
            7'd13:  row = '{CLS_TAB, 8'h00, 8'h00};
            7'd14:  row = '{CLS_SPEC, 8'h60, "~"};
            7'd18:  row = '{CLS_SHIFT, 8'h00, 8'h00};
            7'd20:  row = '{CLS_CTRL, 8'h00, 8'h00};
            7'd21:  row = '{CLS_ALPHA, "q", "Q"};
            7'd22:  row = '{CLS_SPEC, "1", "!"};
            7'd26:  row = '{CLS_ALPHA, "z", "Z"};
            7'd27:  row = '{CLS_ALPHA, "s", "S"};
            7'd28:  row = '{CLS_ALPHA, "a", "A"};
            7'd29:  row = '{CLS_ALPHA, "w", "W"};
            7'd30:  row = '{CLS_SPEC, "2", "@"};
            7'd33:  row = '{CLS_ALPHA, "c", "C"};
            7'd34:  row = '{CLS_ALPHA, "x", "X"};
            7'd35:  row = '{CLS_ALPHA, "d", "D"};
            7'd36:  row = '{CLS_ALPHA, "e", "E"};
            7'd37:  row = '{CLS_SPEC, "4", "$"};
            7'd38:  row = '{CLS_SPEC, "3", "#"};
            7'd41:  row = '{CLS_ALPHA, " ", " "};
            7'd42:  row = '{CLS_ALPHA, "v", "V"};
            7'd43:  row = '{CLS_ALPHA, "f", "F"};
            7'd44:  row = '{CLS_ALPHA, "t", "T"};
            7'd45:  row = '{CLS_ALPHA, "r", "R"};
            7'd46:  row = '{CLS_SPEC, "5", "%"};
            7'd49:  row = '{CLS_ALPHA, "n", "N"};
            7'd50:  row = '{CLS_ALPHA, "b", "B"};
            7'd51:  row = '{CLS_ALPHA, "h", "H"};
            7'd52:  row = '{CLS_ALPHA, "g", "G"};
            7'd53:  row = '{CLS_ALPHA, "y", "Y"};
            7'd54:  row = '{CLS_SPEC, "6", "^"};
            7'd58:  row = '{CLS_ALPHA, "m", "M"};
            7'd59:  row = '{CLS_ALPHA, "j", "J"};
            7'd60:  row = '{CLS_ALPHA, "u", "U"};
            7'd61:  row = '{CLS_SPEC, "7", "&"};
            7'd62:  row = '{CLS_SPEC, "8", "*"};
            7'd65:  row = '{CLS_SPEC, ",", "<"};
            7'd66:  row = '{CLS_ALPHA, "k", "K"};
            7'd67:  row = '{CLS_ALPHA, "i", "I"};
            7'd68:  row = '{CLS_ALPHA, "o", "O"};
            7'd69:  row = '{CLS_SPEC, "0", ")"};
            7'd70:  row = '{CLS_SPEC, "9", "("};
            7'd73:  row = '{CLS_SPEC, ".", ">"};
            7'd74:  row = '{CLS_SPEC, "/", "?"};
            7'd75:  row = '{CLS_ALPHA, "l", "L"};
            7'd76:  row = '{CLS_SPEC, ";", ":"};
            7'd77:  row = '{CLS_ALPHA, "p", "P"};
            7'd78:  row = '{CLS_SPEC, "-", "_"};
            7'd82:  row = '{CLS_SPEC, "'", "\""};
            7'd84:  row = '{CLS_SPEC, "[", "{"};
            7'd85:  row = '{CLS_SPEC, "=", "+"};
            7'd88:  row = '{CLS_CAPS, 8'h00, 8'h00};
            7'd89:  row = '{CLS_SHIFT, 8'h00, 8'h00};
            7'd90:  row = '{CLS_ENTER, 8'h00, 8'h00};
            7'd91:  row = '{CLS_SPEC, "]", "}"};
            7'd93:  row = '{CLS_SPEC, "\\", "|"};
            7'd102: row = '{CLS_BKSP, 8'h00, 8'h00};
            7'd105: row = '{CLS_KPDIG, 8'd1, 8'd1};
            7'd107: row = '{CLS_KPNAV, 8'd4, 8'd2};
            7'd108: row = '{CLS_KPDIG, 8'd7, 8'd1};
            7'd112: row = '{CLS_KPDIG, 8'd0, 8'd1};
            7'd113: row = '{CLS_KPDOT, 8'h00, 8'h00};
            7'd114: row = '{CLS_KPNAV, 8'd2, 8'd1};
            7'd115: row = '{CLS_KPDIG, 8'd5, 8'd1};
            7'd116: row = '{CLS_KPNAV, 8'd6, 8'd3};
            7'd117: row = '{CLS_KPNAV, 8'd8, 8'd0};
            7'd118: row = '{CLS_ESC, 8'h00, 8'h00};
            7'd121: row = '{CLS_SPEC, "+", "+"};
            7'd122: row = '{CLS_KPDIG, 8'd3, 8'd0};
            7'd123: row = '{CLS_KPDASH, 8'h00, 8'h00};
            7'd124: row = '{CLS_SPEC, "*", "*"};
            7'd125: row = '{CLS_KPDIG, 8'd9, 8'd1};
            default: row = '{CLS_NONE, 8'h00, 8'h00};
        endcase
        return row;
    endfunction

    function automatic key_event_t make_event(input event_kind_t kind, input logic [7:0] value,
                                              input logic clicks);
        key_event_t ev;
        ev.click = clicks && kc_en;
        ev.kind  = kind;
        ev.value = value;
        ev.has   = !(kind == KIND_CLICK && !ev.click);
        return ev;
    endfunction

    function automatic key_event_t setup_event(input logic [7:0] ch);
        key_event_t ev;
        logic [7:0] cmd;
        logic       ok;
        ev  = '0;
        ok  = 1'b1;
        cmd = CMD_RESET;
        case (ch)
            "0":     cmd = CMD_RESET;
            "2":     cmd = CMD_TAB_FLIP;
            "3":     cmd = CMD_CLEAR_TABS;
            "4":     cmd = CMD_LOCAL;
            "5":     cmd = CMD_SWITCH;
            "6":     cmd = CMD_VALUE_FLIP;
            "7":     cmd = CMD_UART_TX;
            "8":     cmd = CMD_UART_RX;
            "9":     cmd = CMD_COLUMN_MODE;
            " ":     cmd = CMD_NEXT;
            "s":
            begin
                cmd = CMD_SAVE;
                ok  = shift_on;
            end
            "r":
            begin
                cmd = CMD_RECALL;
                ok  = shift_on;
            end
            default: ok = 1'b0;
        endcase
        if (ok)
            ev = make_event(KIND_SETUP_CMD, cmd, 1'b1);
        return ev;
    endfunction

    function automatic key_event_t char_event(input key_row_t row, input logic setup);
        key_event_t ev;
        logic [7:0] ch;
        logic       alt;
        ev = '0;
        if (setup)
            ev = setup_event(row.lo);
        else if (ctrl_on)
        begin
            ch = row.hi;
            if (ch == CHAR_LBRACE)
                ch = CHAR_LBRACK;
            else if (ch == CHAR_BAR)
                ch = CHAR_BSLASH;
            else if (ch == CHAR_RBRACE)
                ch = CHAR_RBRACK;
            if (ch >= CHAR_AT && ch <= CHAR_UNDER)
                ev = make_event(KIND_ASCII, ch - CHAR_AT, 1'b1);
        end
        else
        begin
            alt = (row.cls == CLS_ALPHA && caps_on) != shift_on;
            ev  = make_event(KIND_ASCII, alt ? row.hi : row.lo, 1'b1);
        end
        return ev;
    endfunction

    function automatic key_event_t decode_scan(input logic [7:0] code, input logic setup);
        key_event_t ev;
        key_row_t   row;
        logic       brk;
        logic       ext;
        logic [7:0] cmd;
        ev = '0;
        if (code >= ROM_DEPTH)
        begin
            if (code == CODE_BREAK)
                brk_pend = 1'b1;
            else if (code == CODE_EXTENDED)
                ext_pend = 1'b1;
            return ev;
        end
        row      = key_row(code[6:0]);
        brk      = brk_pend;
        ext      = ext_pend;
        brk_pend = 1'b0;
        ext_pend = 1'b0;
        case (row.cls)
            CLS_SHIFT: shift_on = !brk;
            CLS_CTRL:  ctrl_on = !brk;
            CLS_CAPS:
            begin
                if (!brk)
                begin
                    caps_on = !caps_on;
                    ev = make_event(KIND_CLICK, 8'h00, 1'b1);
                end
            end
            default:
            begin
                if (!brk)
                begin
                    case (row.cls)
                        CLS_ALPHA, CLS_SPEC: ev = char_event(row, setup);
                        CLS_PF:       ev = make_event(KIND_PF, row.lo, 1'b1);
                        CLS_SETUPKEY: ev = make_event(KIND_SETUP, 8'h00, 1'b1);
                        CLS_TAB:
                            ev = setup ? make_event(KIND_SETUP_CMD, CMD_NEXT, 1'b1)
                                       : make_event(KIND_ASCII, CHAR_TAB, 1'b1);
                        CLS_BKSP:
                            ev = setup ? make_event(KIND_SETUP_CMD, CMD_PREVIOUS, 1'b1)
                                       : make_event(KIND_ASCII, CHAR_BS, 1'b1);
                        CLS_ESC:
                            if (!setup)
                                ev = make_event(KIND_ASCII, CHAR_ESC, 1'b1);
                        CLS_ENTER:
                        begin
                            if (setup)
                            begin
                                if (!ext)
                                    ev = make_event(KIND_SETUP_CMD, CMD_NEXT, 1'b1);
                            end
                            else
                                ev = make_event(ext ? KIND_KP_ENTER : KIND_RETURN, 8'h00, 1'b1);
                        end
                        CLS_KPDIG: ev = make_event(KIND_KP_DIGIT, row.lo, row.hi != 8'h00);
                        CLS_KPDOT:
                            ev = ext ? make_event(KIND_ASCII, CHAR_DEL, 1'b1)
                                     : make_event(KIND_KP_DOT, 8'h00, 1'b1);
                        CLS_KPDASH:
                            if (!setup)
                                ev = make_event(KIND_KP_DASH, 8'h00, 1'b1);
                        CLS_KPNAV:
                        begin
                            if (setup)
                            begin
                                case (row.lo)
                                    8'd2:    cmd = CMD_DIMMER;
                                    8'd4:    cmd = CMD_PREVIOUS;
                                    8'd6:    cmd = CMD_NEXT;
                                    default: cmd = CMD_BRIGHTER;
                                endcase
                                ev = make_event(KIND_SETUP_CMD, cmd, 1'b1);
                            end
                            else if (ext)
                                ev = make_event(KIND_ARROW, row.hi, 1'b1);
                            else
                                ev = make_event(KIND_KP_DIGIT, row.lo, 1'b1);
                        end
                        default: ev = '0;
                    endcase
                end
            end
        endcase
        return ev;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    endtask

    task automatic send_item(input logic [7:0] code, input logic setup);
        key_event_t ev;
        while (!steady && $urandom_range(99) < 9)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        scan_code  <= code;
        setup_mode <= setup;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ev = decode_scan(code, setup);
        if (ev.has)
            pending_events.push_back(ev);
        if (code < ROM_DEPTH || code == CODE_BREAK || code == CODE_EXTENDED)
            items_sent++;
        @(negedge clk);
    endtask

    task automatic set_keyclick(input logic enable);
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        keyclick_we    <= 1'b1;
        keyclick_wdata <= enable;
        @(negedge clk);
        keyclick_we <= 1'b0;
        kc_en = enable;
    endtask

    always @(negedge clk)
        out_stall <= rst_n && !steady && ($urandom_range(99) < 9);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_events.size() == 0)
                report_mismatch("unexpected result, kind", int'(event_kind), 0);
            else
            begin
                if (event_kind != pending_events[0].kind)
                    report_mismatch("event_kind", int'(event_kind),
                                    int'(pending_events[0].kind));
                if (event_value != pending_events[0].value)
                    report_mismatch("event_value", int'(event_value),
                                    int'(pending_events[0].value));
                if (click != pending_events[0].click)
                    report_mismatch("click", int'(click), int'(pending_events[0].click));
                void'(pending_events.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic test_directed_keys();
        send_item(SC_LOWEST, 1'b0);
        send_item(SC_TOP, 1'b1);
        send_item(ROM_DEPTH, 1'b0);
        send_item(SC_A, 1'b0);
        send_item(SC_LSHIFT, 1'b0);
        send_item(SC_A, 1'b0);
        send_item(SC_CAPS, 1'b0);
        send_item(SC_A, 1'b0);
        send_item(CODE_BREAK, 1'b0);
        send_item(SC_LSHIFT, 1'b0);
        send_item(SC_CTRL, 1'b0);
        send_item(SC_LBRACK, 1'b0);
        send_item(SC_1, 1'b0);
        send_item(CODE_BREAK, 1'b0);
        send_item(SC_CTRL, 1'b0);
        send_item(CODE_EXTENDED, 1'b0);
        send_item(SC_KP_DOT, 1'b0);
        send_item(SC_KP_DOT, 1'b0);
        send_item(SC_KP3, 1'b0);
        send_item(SC_KP_DASH, 1'b0);
        send_item(CODE_EXTENDED, 1'b0);
        send_item(SC_ENTER, 1'b0);
        send_item(SC_ENTER, 1'b0);
        send_item(CODE_EXTENDED, 1'b0);
        send_item(SC_KP8, 1'b0);
        send_item(SC_PF1, 1'b0);
        send_item(SC_SETUP, 1'b0);
        send_item(SC_KP9, 1'b0);
    endtask

    task automatic test_directed_setup();
        send_item(SC_ZERO, 1'b1);
        send_item(SC_S, 1'b1);
        send_item(SC_ESC, 1'b1);
        send_item(SC_KP_DASH, 1'b1);
        send_item(CODE_EXTENDED, 1'b1);
        send_item(SC_ENTER, 1'b1);
        send_item(SC_KP4, 1'b1);
        send_item(SC_RSHIFT, 1'b1);
        send_item(SC_R, 1'b1);
        send_item(CODE_BREAK, 1'b1);
        send_item(SC_RSHIFT, 1'b1);
    endtask

    task automatic test_random_typing(input int count, input int setup_pct);
        int         stop_at;
        int         r;
        logic [7:0] code;
        logic       setup;
        logic       ext;
        logic       brk;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            r     = $urandom_range(99);
            setup = ($urandom_range(99) < setup_pct);
            if (r < 8)
                send_item(8'($urandom_range(255)), 1'($urandom_range(1)));
            else if (r < 13)
                send_item($urandom_range(1) ? CODE_BREAK : CODE_EXTENDED, setup);
            else
            begin
                ext = ($urandom_range(99) < 20);
                if (r < 35)
                begin
                    case ($urandom_range(3))
                        0:       code = SC_LSHIFT;
                        1:       code = SC_RSHIFT;
                        2:       code = SC_CTRL;
                        default: code = SC_CAPS;
                    endcase
                    brk = 1'($urandom_range(1));
                end
                else
                begin
                    if (r < 42)
                        code = 8'($urandom_range(ROM_DEPTH - 1));
                    else
                        code = key_codes[$urandom_range(key_codes.size() - 1)];
                    brk = ($urandom_range(99) < 25);
                end
                if (ext)
                    send_item(CODE_EXTENDED, 1'($urandom_range(1)));
                if (brk)
                    send_item(CODE_BREAK, 1'($urandom_range(1)));
                send_item(code, setup);
            end
        end
    endtask

    task automatic test_quiet_keyclick_off();
        set_keyclick(1'b0);
        steady = 1'b1;
        test_random_typing(450, 20);
        steady = 1'b0;
    endtask

    task automatic test_setup_heavy();
        set_keyclick(1'b1);
        test_random_typing(520, 50);
    endtask

    initial
    begin
        for (int i = 0; i < ROM_DEPTH; i++)
            if (key_row(7'(i)).cls != CLS_NONE)
                key_codes.push_back(8'(i));
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_keys();
        test_directed_setup();
        test_random_typing(450, 20);
        test_quiet_keyclick_off();
        test_setup_heavy();
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
